// ===== design/stable_priority_queue_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the stable priority queue
// Small wrappers around concurrent assertions, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication.
`define SPQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared codes and types for the stable priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OccW    = 5;

  // request opcodes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  // result status codes
  localparam logic [StatusW-1:0] ST_INSERTED  = 2'd0;
  localparam logic [StatusW-1:0] ST_REMOVED   = 2'd1;
  localparam logic [StatusW-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [StatusW-1:0] ST_OVERFLOW  = 2'd3;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;  // insert new entry, shift tail right
    logic rem;  // drop head, shift everything left
  } spq_ctrl_t;

endpackage

`default_nettype wire

// ===== design/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, compares its priority with
// the incoming one, and loads itself, the new entry or a neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
  input  wire logic                                clk_i,
  input  wire spq_pkg::spq_ctrl_t                  ctrl_i,
  input  wire logic                                occupied_i,
  input  wire logic                                prev_after_i,
  input  wire logic signed [spq_pkg::WordW-1:0]    new_value_i,
  input  wire logic signed [spq_pkg::WordW-1:0]    new_prio_i,
  input  wire logic signed [spq_pkg::WordW-1:0]    left_value_i,
  input  wire logic signed [spq_pkg::WordW-1:0]    left_prio_i,
  input  wire logic signed [spq_pkg::WordW-1:0]    right_value_i,
  input  wire logic signed [spq_pkg::WordW-1:0]    right_prio_i,
  output logic signed [spq_pkg::WordW-1:0]         value_o,
  output logic signed [spq_pkg::WordW-1:0]         prio_o,
  output logic                                     after_o
);

  logic signed [spq_pkg::WordW-1:0] value_q, value_d;
  logic signed [spq_pkg::WordW-1:0] prio_q, prio_d;

  // new entry belongs behind this one (ties keep arrival order)
  assign after_o = occupied_i && (prio_q >= new_prio_i);

  always_comb begin
    value_d = value_q;
    prio_d  = prio_q;
    if (ctrl_i.ins) begin
      if (!after_o) begin
        if (prev_after_i) begin
          value_d = new_value_i;
          prio_d  = new_prio_i;
        end else begin
          value_d = left_value_i;
          prio_d  = left_prio_i;
        end
      end
    end else if (ctrl_i.rem) begin
      value_d = right_value_i;
      prio_d  = right_prio_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    prio_q  <= prio_d;
  end

  assign value_o = value_q;
  assign prio_o  = prio_q;

endmodule

`default_nettype wire

// ===== design/stable_priority_queue.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue
// Sorted priority queue built as a shifting chain of compare cells.
// ----------------------------------------------------------------------------
// Holds up to DEPTH (value, priority) entries, highest priority at the head,
// first in first out among equal priorities. Every request (insert or remove)
// gets exactly one result: removed value, status and occupancy. The block
// takes one request per cycle; its result appears in the output register on
// the next cycle. That rate comes from the cell chain: every cell compares
// its priority with the new one in parallel, and each cell then loads from
// itself, the new entry, or a neighbor. Back-pressure: a request is stalled
// only while a result sits unaccepted in the output register.
// Entry storage has no reset; only slots below the entry count are ever used.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stable_priority_queue_macros.svh"

module stable_priority_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // request channel
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              func_i,
  input  wire logic signed [spq_pkg::WordW-1:0]  item_value_i,
  input  wire logic signed [spq_pkg::WordW-1:0]  item_priority_i,
  // result channel
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [spq_pkg::WordW-1:0]       removed_value_o,
  output logic [spq_pkg::StatusW-1:0]            status_o,
  output logic [spq_pkg::OccW-1:0]               occupancy_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic                 accept;
  logic                 full, empty;
  logic [CntW-1:0]      count_q, count_d;
  spq_pkg::spq_ctrl_t   ctrl;

  // cell chain
  logic signed [spq_pkg::WordW-1:0] cell_value [DEPTH];
  logic signed [spq_pkg::WordW-1:0] cell_prio  [DEPTH];
  logic [DEPTH-1:0]                 cell_after;

  // output register
  logic                             out_valid_q;
  logic signed [spq_pkg::WordW-1:0] removed_value_q, removed_value_d;
  logic [spq_pkg::StatusW-1:0]      status_q, status_d;
  logic [spq_pkg::OccW-1:0]         occupancy_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CntW'(DEPTH));
  assign empty      = (count_q == '0);

  // Only legal operations move the chain; overflow and underflow leave it.
  assign ctrl.ins = accept && (func_i == spq_pkg::FUNC_INSERT) && !full;
  assign ctrl.rem = accept && (func_i == spq_pkg::FUNC_REMOVE) && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                             prev_after;
    logic signed [spq_pkg::WordW-1:0] left_value, left_prio;
    logic signed [spq_pkg::WordW-1:0] right_value, right_prio;

    if (i == 0) begin : g_head
      // head: new entry lands here unless it ranks behind the head itself
      assign prev_after = 1'b1;
      assign left_value = item_value_i;
      assign left_prio  = item_priority_i;
    end else begin : g_body
      assign prev_after = cell_after[i-1];
      assign left_value = cell_value[i-1];
      assign left_prio  = cell_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      // tail slot falls out of range after a remove; its content is stale
      assign right_value = cell_value[i];
      assign right_prio  = cell_prio[i];
    end else begin : g_inner
      assign right_value = cell_value[i+1];
      assign right_prio  = cell_prio[i+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .occupied_i    (count_q > CntW'(i)),
      .prev_after_i  (prev_after),
      .new_value_i   (item_value_i),
      .new_prio_i    (item_priority_i),
      .left_value_i  (left_value),
      .left_prio_i   (left_prio),
      .right_value_i (right_value),
      .right_prio_i  (right_prio),
      .value_o       (cell_value[i]),
      .prio_o        (cell_prio[i]),
      .after_o       (cell_after[i])
    );
  end

  // next count and result fields
  always_comb begin
    count_d         = count_q;
    removed_value_d = '0;
    status_d        = spq_pkg::ST_INSERTED;
    if (func_i == spq_pkg::FUNC_INSERT) begin
      if (full) begin
        status_d = spq_pkg::ST_OVERFLOW;
      end else begin
        count_d  = count_q + CntW'(1);
        status_d = spq_pkg::ST_INSERTED;
      end
    end else begin
      if (empty) begin
        removed_value_d = '1;  // -1 on underflow
        status_d        = spq_pkg::ST_UNDERFLOW;
      end else begin
        removed_value_d = cell_value[0];
        count_d         = count_q - CntW'(1);
        status_d        = spq_pkg::ST_REMOVED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      removed_value_q <= removed_value_d;
      status_q        <= status_d;
      occupancy_q     <= spq_pkg::OccW'(count_d);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign removed_value_o = removed_value_q;
  assign status_o        = status_q;
  assign occupancy_o     = occupancy_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `SPQ_ASSERT_IMPLY(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CntW'(DEPTH), "count above depth")
  `SPQ_ASSERT_IMPLY(a_underflow_val, clk_i, rst_ni, out_valid_q && status_q == spq_pkg::ST_UNDERFLOW, removed_value_q == -1 && occupancy_q == '0, "bad underflow result")
  `SPQ_ASSERT_NEXT(a_insert_count, clk_i, rst_ni, ctrl.ins, count_q == $past(count_q) + CntW'(1), "insert did not bump count")
  `SPQ_ASSERT_IMPLY(a_one_op, clk_i, rst_ni, 1'b1, !(ctrl.ins && ctrl.rem), "insert and remove together")

endmodule

`default_nettype wire

// ===== dv/tb_stable_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stable_priority_queue
// Self-checking bench for the sorted-list priority queue.
// ----------------------------------------------------------------------------
// A short table of directed requests is sent first: underflow after reset,
// extreme values and priorities, ties at zero and at the top, and a fill up to overflow.
// Random requests follow in chunks that lean toward insert, toward remove, or
// neither, so the queue swings between empty and full many times. Every
// accepted request runs through a queue model kept in the bench; its result is
// queued and compared with the next result the block hands out. Both channels
// idle at random, except for one long stretch at full rate.
// ----------------------------------------------------------------------------

module tb_stable_priority_queue;

  localparam int unsigned QDepth         = 16;
  localparam int unsigned IdlePct        = 20;
  localparam int unsigned RandomRequests = 400;
  localparam int unsigned ChunkLen       = 40;
  localparam int unsigned StallLimit     = 1000;
  localparam int unsigned MaxReported    = 10;

  localparam logic signed [spq_pkg::WordW-1:0] PrioMax = 32'sh7FFF_FFFF;
  localparam logic signed [spq_pkg::WordW-1:0] PrioMin = 32'sh8000_0000;

  typedef struct packed {
    logic signed [spq_pkg::WordW-1:0] value;
    logic [spq_pkg::StatusW-1:0]      status;
    logic [spq_pkg::OccW-1:0]         occupancy;
  } queue_result_t;

  typedef struct packed {
    logic signed [spq_pkg::WordW-1:0] value;
    logic signed [spq_pkg::WordW-1:0] prio;
  } queue_entry_t;

  // One row of the directed table. Rows with typed set carry a hand-written
  // result; the others are checked against the queue model.
  typedef struct {
    logic                             func;
    logic signed [spq_pkg::WordW-1:0] value;
    logic signed [spq_pkg::WordW-1:0] prio;
    bit                               typed;
    queue_result_t                    result;
  } request_row_t;

  // DUT inputs, all known from time zero
  logic                             clk_i           = 1'b0;
  logic                             rst_ni          = 1'b0;
  logic                             in_valid_i      = 1'b0;
  logic                             func_i          = spq_pkg::FUNC_INSERT;
  logic signed [spq_pkg::WordW-1:0] item_value_i    = '0;
  logic signed [spq_pkg::WordW-1:0] item_priority_i = '0;
  logic                             out_stall_i     = 1'b0;

  // DUT outputs
  logic                             in_stall_o;
  logic                             out_valid_o;
  logic signed [spq_pkg::WordW-1:0] removed_value_o;
  logic [spq_pkg::StatusW-1:0]      status_o;
  logic [spq_pkg::OccW-1:0]         occupancy_o;

  queue_entry_t  held_entries[$];   // model of the sorted store, head first
  queue_result_t results_due[$];    // results owed by the block, oldest first
  request_row_t  directed_rows[$];
  int unsigned   error_count = 0;
  int unsigned   idle_cycles = 0;
  bit            steady_flow = 1'b0; // no idling on either side while set

  stable_priority_queue #(
    .DEPTH(QDepth)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .item_value_i   (item_value_i),
    .item_priority_i(item_priority_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .removed_value_o(removed_value_o),
    .status_o       (status_o),
    .occupancy_o    (occupancy_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one request to the queue model and return the result it owes.
  // A new entry goes behind every held entry of greater or equal priority.
  function automatic queue_result_t model_request(logic f,
                                                  logic signed [spq_pkg::WordW-1:0] v,
                                                  logic signed [spq_pkg::WordW-1:0] p);
    queue_result_t res;
    queue_entry_t  e;
    int            pos;
    res.value = '0;
    if (f == spq_pkg::FUNC_INSERT) begin
      if (held_entries.size() >= QDepth) begin
        res.status = spq_pkg::ST_OVERFLOW;  // full: entry dropped, store untouched
      end else begin
        pos = 0;
        while (pos < held_entries.size() &&
               $signed(held_entries[pos].prio) >= $signed(p))
          pos++;
        e.value = v;
        e.prio  = p;
        held_entries.insert(pos, e);
        res.status = spq_pkg::ST_INSERTED;
      end
    end else if (held_entries.size() == 0) begin
      res.value  = -1;
      res.status = spq_pkg::ST_UNDERFLOW;
    end else begin
      e = held_entries.pop_front();
      res.value  = e.value;
      res.status = spq_pkg::ST_REMOVED;
    end
    res.occupancy = spq_pkg::OccW'(held_entries.size());
    return res;
  endfunction

  task automatic add_row(logic f, logic signed [spq_pkg::WordW-1:0] v,
                         logic signed [spq_pkg::WordW-1:0] p,
                         bit typed = 1'b0, queue_result_t res = '0);
    request_row_t row;
    row.func   = f;
    row.value  = v;
    row.prio   = p;
    row.typed  = typed;
    row.result = res;
    directed_rows.push_back(row);
  endtask

  // Present one request, hold it until accepted, then log what it owes.
  // Called at a rising edge; valid is changed at most once per edge.
  // Each idle cycle is drawn on its own, so about one cycle in five idles.
  task automatic send_request(logic f, logic signed [spq_pkg::WordW-1:0] v,
                              logic signed [spq_pkg::WordW-1:0] p,
                              bit typed, queue_result_t typed_res);
    queue_result_t predicted;
    while (!steady_flow && $urandom_range(0, 99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    func_i          <= f;
    item_value_i    <= v;
    item_priority_i <= p;
    do @(posedge clk_i); while (in_stall_o);
    predicted = model_request(f, v, p);
    results_due.push_back(typed ? typed_res : predicted);
  endtask

  // Hold off new requests until every owed result has come out.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (results_due.size() != 0);
  endtask

  // Result side back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= !steady_flow && ($urandom_range(0, 99) < IdlePct);
  end

  // Result checker: every accepted result must match the oldest owed one
  always @(posedge clk_i) begin
    queue_result_t owed;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (results_due.size() == 0) begin
        error_count++;
        if (error_count <= MaxReported)
          $display("%0t: result with nothing owed: value %0d status %0d occ %0d",
                   $time, removed_value_o, status_o, occupancy_o);
      end else begin
        owed = results_due.pop_front();
        if ({removed_value_o, status_o, occupancy_o} !== owed) begin
          error_count++;
          if (error_count <= MaxReported)
            $display({"%0t: mismatch: exp value %0d status %0d occ %0d, ",
                      "got value %0d status %0d occ %0d"},
                     $time, owed.value, owed.status, owed.occupancy,
                     removed_value_o, status_o, occupancy_o);
        end
      end
    end
  end

  // Watchdog: ends the run after too many cycles with no handshake at all
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= StallLimit) begin
        $display("stable_priority_queue verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned                      insert_pct;
    logic                             f;
    logic signed [spq_pkg::WordW-1:0] v;
    logic signed [spq_pkg::WordW-1:0] p;

    insert_pct = 50;

    // --- directed table ---
    // remove from the empty queue right after reset
    add_row(spq_pkg::FUNC_REMOVE, 32'sh5A5A_5A5A, 32'sh5A5A_5A5A, 1'b1,
            queue_result_t'{value: -1, status: spq_pkg::ST_UNDERFLOW, occupancy: '0});
    // extreme values at extreme priorities
    add_row(spq_pkg::FUNC_INSERT, PrioMin, PrioMax, 1'b1,
            queue_result_t'{value: '0, status: spq_pkg::ST_INSERTED,
                            occupancy: spq_pkg::OccW'(1)});
    add_row(spq_pkg::FUNC_INSERT, PrioMax, PrioMin, 1'b1,
            queue_result_t'{value: '0, status: spq_pkg::ST_INSERTED,
                            occupancy: spq_pkg::OccW'(2)});
    // ties at zero keep arrival order; a tie at the top lands behind its twin
    add_row(spq_pkg::FUNC_INSERT, 1, 0);
    add_row(spq_pkg::FUNC_INSERT, 2, 0);
    add_row(spq_pkg::FUNC_INSERT, -1, PrioMax);
    add_row(spq_pkg::FUNC_INSERT, 3, -1);
    add_row(spq_pkg::FUNC_INSERT, 4, 0);
    // head is the first top-priority entry, then its later twin
    add_row(spq_pkg::FUNC_REMOVE, 0, 0, 1'b1,
            queue_result_t'{value: PrioMin, status: spq_pkg::ST_REMOVED,
                            occupancy: spq_pkg::OccW'(6)});
    add_row(spq_pkg::FUNC_REMOVE, -1, -1);
    // fill the remaining slots, mixing ties into the middle and the top
    for (int k = 0; k < 11; k++)
      add_row(spq_pkg::FUNC_INSERT, 10 + k, (k % 5 == 4) ? PrioMax : k % 3 - 1);
    // insert into a full queue is dropped
    add_row(spq_pkg::FUNC_INSERT, -1, PrioMax, 1'b1,
            queue_result_t'{value: '0, status: spq_pkg::ST_OVERFLOW,
                            occupancy: spq_pkg::OccW'(QDepth)});

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_request(directed_rows[i].func, directed_rows[i].value, directed_rows[i].prio,
                   directed_rows[i].typed, directed_rows[i].result);
    drain_results();

    // --- random requests ---
    // Each chunk leans toward filling, draining, or neither, so overflow and
    // underflow both come up repeatedly. Chunk 3 runs without idling; before
    // chunk 6 the sender waits for the queue of owed results to empty.
    for (int n = 0; n < RandomRequests; n++) begin
      if (n % ChunkLen == 0) begin
        steady_flow = (n / ChunkLen == 3);
        if (n / ChunkLen == 6)
          drain_results();
        case ($urandom_range(0, 2))
          0:       insert_pct = 85;
          1:       insert_pct = 15;
          default: insert_pct = 50;
        endcase
      end
      f = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::FUNC_INSERT
                                                : spq_pkg::FUNC_REMOVE;
      v = $urandom;
      // narrow priorities make ties common; extremes keep the sign edge busy
      case ($urandom_range(0, 9))
        0, 1, 2, 3: p = spq_pkg::WordW'($urandom_range(0, 4)) - spq_pkg::WordW'(2);
        4:          p = PrioMax;
        5:          p = PrioMin;
        default:    p = $urandom;
      endcase
      send_request(f, v, p, 1'b0, '0);
    end
    steady_flow = 1'b0;

    drain_results();
    repeat (4) @(posedge clk_i);

    if (error_count == 0) begin
      $display("stable_priority_queue verification clean");
    end else begin
      $display("stable_priority_queue verification failed");
    end
    $finish;
  end

endmodule
